>>> src/signed_int_to_decimal_ascii_macros.svh
// Assertion macros used by the checker file of the integer-to-text block.
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_MACROS_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SIDA_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("sida assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is asserted.
`define SIDA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("sida assertion failed: next-cycle implication");

`endif

>>> src/sida_pkg.sv
// Package: widths, ASCII codes and pipeline types of the integer-to-text block.
`default_nettype none
package sida_pkg;

	// Magnitude and decimal widths
	localparam int SIDA_MAG_W           = 32;
	localparam int SIDA_NDIG            = 10;
	localparam int SIDA_BCD_W           = 4 * SIDA_NDIG;
	localparam int SIDA_IDX_W           = 4;
	localparam int SIDA_STEPS_PER_STAGE = 8;

	// Double-dabble digit correction
	localparam logic [3:0] SIDA_DD_LIMIT = 4'd5;
	localparam logic [3:0] SIDA_DD_ADJ   = 4'd3;

	// ASCII codes
	localparam logic [7:0] SIDA_ASCII_ZERO  = 8'd48;
	localparam logic [7:0] SIDA_ASCII_NINE  = 8'd57;
	localparam logic [7:0] SIDA_ASCII_MINUS = 8'd45;

	typedef logic [SIDA_IDX_W-1:0]          sida_idx_t;
	typedef logic [SIDA_NDIG-1:0][3:0]      sida_digits_t;

	// Conversion work carried down the pipeline
	typedef struct packed {
		logic                  neg;
		logic [SIDA_BCD_W-1:0] bcd;
		logic [SIDA_MAG_W-1:0] bin;
	} sida_work_t;

endpackage
`default_nettype wire

>>> src/sida_dabble_stage.sv
// One registered pipeline stage of the binary-to-BCD shift-and-add-3 conversion.
`default_nettype none
module sida_dabble_stage #(
	parameter int STEPS = sida_pkg::SIDA_STEPS_PER_STAGE
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 en,
	input  wire                 in_valid,
	input  sida_pkg::sida_work_t in_work,
	output logic                out_valid,
	output sida_pkg::sida_work_t out_work
);
	import sida_pkg::*;

	sida_work_t w;
	logic       valid_sn;
	sida_work_t work_sn;

	// STEPS shift iterations; digits inside one iteration are independent
	always_comb begin
		w = in_work;
		for (int s = 0; s < STEPS; s++) begin
			for (int d = 0; d < SIDA_NDIG; d++) begin
				if (w.bcd[d*4 +: 4] >= SIDA_DD_LIMIT) begin
					w.bcd[d*4 +: 4] = w.bcd[d*4 +: 4] + SIDA_DD_ADJ;
				end
			end
			w.bcd = {w.bcd[SIDA_BCD_W-2:0], w.bin[SIDA_MAG_W-1]};
			w.bin = {w.bin[SIDA_MAG_W-2:0], 1'b0};
		end
	end

	// Stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_sn <= 1'b0;
		end else if (en) begin
			valid_sn <= in_valid;
		end
	end

	// Stage payload
	always_ff @(posedge clk) begin
		if (en) begin
			work_sn <= w;
		end
	end

	assign out_valid = valid_sn;
	assign out_work  = work_sn;

endmodule
`default_nettype wire

>>> src/signed_int_to_decimal_ascii.sv
// The single-character output serializer emits the characters of each number in turn
// and sets the throughput; the conversion pipeline waits behind it.
// Conversion is a pipelined shift-and-add-3, STEPS_PER_STAGE shift steps per stage (the last stage takes the rest).
// Results cannot be held off; busy rises only when the serializer is still emitting.
// Reset (arst_n low) empties the pipeline and serializer and clears strobe at once.
`default_nettype none
module signed_int_to_decimal_ascii #(
	parameter int STEPS_PER_STAGE = sida_pkg::SIDA_STEPS_PER_STAGE
) (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire                                  start,
	output logic                                 busy,
	input  wire signed [sida_pkg::SIDA_MAG_W-1:0] value,
	output logic [7:0]                           character,
	output logic                                 last,
	output logic                                 strobe
);
	import sida_pkg::*;

	localparam int NUM_STAGES = (SIDA_MAG_W + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;

	logic                  adv;
	logic                  accept;
	logic                  valid_s1;
	sida_work_t            work_s1;
	logic [NUM_STAGES:0]   chain_valid;
	sida_work_t            chain_work [NUM_STAGES+1];

	logic                  ser_free;
	logic                  ser_load;
	sida_idx_t             top_idx;
	sida_digits_t          res_digits;

	sida_digits_t          bcd_q;
	sida_idx_t             idx_q;
	logic                  sign_q;
	logic                  active_q;

	// Pipeline moves as one; it holds only when the serializer cannot take the tail item
	assign ser_free = !active_q || (!sign_q && (idx_q == '0));
	assign adv      = !chain_valid[NUM_STAGES] || ser_free;
	assign busy     = !adv;
	assign accept   = start && !busy;
	assign ser_load = chain_valid[NUM_STAGES] && ser_free;

	// Stage 1: sign and magnitude
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			work_s1.neg <= value[SIDA_MAG_W-1];
			work_s1.bcd <= '0;
			work_s1.bin <= value[SIDA_MAG_W-1] ? (~$unsigned(value) + 1'b1) : $unsigned(value);
		end
	end

	assign chain_valid[0] = valid_s1;
	assign chain_work[0]  = work_s1;

	// Conversion stages
	for (genvar k = 0; k < NUM_STAGES; k++) begin : g_dd
		localparam int STG_STEPS = (k == NUM_STAGES - 1) ?
			(SIDA_MAG_W - k * STEPS_PER_STAGE) : STEPS_PER_STAGE;
		sida_dabble_stage #(
			.STEPS(STG_STEPS)
		) u_stage (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (adv),
			.in_valid (chain_valid[k]),
			.in_work  (chain_work[k]),
			.out_valid(chain_valid[k+1]),
			.out_work (chain_work[k+1])
		);
	end

	// Most significant nonzero digit; zero gives digit 0 alone
	assign res_digits = chain_work[NUM_STAGES].bcd;
	always_comb begin
		top_idx = '0;
		for (int d = 0; d < SIDA_NDIG; d++) begin
			if (res_digits[d] != 4'd0) begin
				top_idx = sida_idx_t'(d);
			end
		end
	end

	// Serializer state: sign first, then digits from top_idx down to 0
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			sign_q   <= 1'b0;
			idx_q    <= '0;
		end else if (ser_load) begin
			active_q <= 1'b1;
			sign_q   <= chain_work[NUM_STAGES].neg;
			idx_q    <= top_idx;
		end else if (active_q) begin
			if (sign_q) begin
				sign_q <= 1'b0;
			end else if (idx_q == '0) begin
				active_q <= 1'b0;
			end else begin
				idx_q <= sida_idx_t'(idx_q - 1'b1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ser_load) begin
			bcd_q <= res_digits;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe    <= 1'b0;
			character <= '0;
			last      <= 1'b0;
		end else begin
			strobe    <= active_q;
			character <= sign_q ? SIDA_ASCII_MINUS : (SIDA_ASCII_ZERO + {4'd0, bcd_q[idx_q]});
			last      <= !sign_q && (idx_q == '0);
		end
	end

endmodule
`default_nettype wire

>>> src/sida_checker.sv
// Port-level checker for the integer-to-text block, bound to the top level.
`default_nettype none
`include "signed_int_to_decimal_ascii_macros.svh"
module sida_checker (
	input wire       clk,
	input wire       arst_n,
	input wire       busy,
	input wire [7:0] character,
	input wire       last,
	input wire       strobe
);
	import sida_pkg::*;

	logic is_minus;
	logic is_digit;

	assign is_minus = (character == SIDA_ASCII_MINUS);
	assign is_digit = (character >= SIDA_ASCII_ZERO) && (character <= SIDA_ASCII_NINE);

	// Only sign or digit characters appear
	`SIDA_ASSERT_IMPLY(a_char_set, clk, arst_n, strobe, is_minus || is_digit)
	// A sign never ends a number
	`SIDA_ASSERT_IMPLY(a_sign_not_last, clk, arst_n, strobe && is_minus, !last)
	// A sign is followed directly by a digit
	`SIDA_ASSERT_NEXT(a_sign_then_digit, clk, arst_n, strobe && is_minus, strobe && is_digit)
	// Characters of one number come without gaps
	`SIDA_ASSERT_NEXT(a_no_gap, clk, arst_n, strobe && !last, strobe)
	// Busy means a number is mid-emission, so a character follows
	`SIDA_ASSERT_NEXT(a_busy_emits, clk, arst_n, busy, strobe)

endmodule

bind signed_int_to_decimal_ascii sida_checker u_sida_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.busy     (busy),
	.character(character),
	.last     (last),
	.strobe   (strobe)
);
`default_nettype wire

>>> dv/signed_int_to_decimal_ascii_tb.sv
// Testbench for the signed integer to decimal ASCII converter.
`timescale 1ns / 1ps

module signed_int_to_decimal_ascii_tb;

	localparam int STALL_LIMIT = 2000;  // cycles with no item moving before giving up
	localparam int DRAIN_CYCLES = 20;   // pipeline latency plus margin
	localparam int MAX_PRINTED = 100;

	// One expected output character
	typedef struct {
		logic [7:0]         ch;
		logic               last;
		logic signed [31:0] number;
	} text_char_t;

	// Predicts the decimal text of each accepted number and checks the characters
	class decimal_text_board;
		text_char_t pending_chars[$];
		int         mismatch_count;

		function new();
			mismatch_count = 0;
		endfunction

		task report_mismatch(input string msg);
			if (mismatch_count < MAX_PRINTED) begin
				$display("[%0t] MISMATCH: %s", $realtime, msg);
			end
			mismatch_count++;
		endtask

		// Expected characters: optional minus, then digits most significant first
		function void note_number(input logic signed [31:0] number);
			logic [31:0] magnitude;
			logic [3:0]  digits[sida_pkg::SIDA_NDIG];
			int          n_digits;
			text_char_t  item;
			item.number = number;
			// unsigned negate handles the most negative value
			magnitude = number[31] ? 32'd0 - number : number;
			n_digits = 0;
			do begin
				digits[n_digits] = 4'(magnitude % 32'd10);
				magnitude = magnitude / 32'd10;
				n_digits++;
			end while (magnitude != 0);
			if (number[31]) begin
				item.ch = sida_pkg::SIDA_ASCII_MINUS;
				item.last = 1'b0;
				pending_chars.push_back(item);
			end
			for (int i = n_digits - 1; i >= 0; i--) begin
				item.ch = sida_pkg::SIDA_ASCII_ZERO + 8'(digits[i]);
				item.last = (i == 0);
				pending_chars.push_back(item);
			end
		endfunction

		task check_char(input logic [7:0] ch, input logic last);
			text_char_t want;
			if (pending_chars.size() == 0) begin
				report_mismatch($sformatf("char %0d last %0b with no number pending", ch, last));
			end else begin
				want = pending_chars.pop_front();
				if (ch !== want.ch) begin
					report_mismatch($sformatf("number %0d: char %0d, expected %0d",
						want.number, ch, want.ch));
				end
				if (last !== want.last) begin
					report_mismatch($sformatf("number %0d: last %0b, expected %0b",
						want.number, last, want.last));
				end
			end
		endtask
	endclass

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic signed [31:0] in_value = '0;
	logic               busy;
	logic [7:0]         character;
	logic               last;
	logic               strobe;

	decimal_text_board board = new();
	int                idle_cycles = 0;

	signed_int_to_decimal_ascii dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.value     (in_value),
		.character (character),
		.last      (last),
		.strobe    (strobe)
	);

	always #2 clk = ~clk;

	// Monitor: accepted numbers, emitted characters, and the stall watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy) begin
				board.note_number(in_value);
			end
			if (strobe) begin
				board.check_char(character, last);
			end
		end
		if ((start && !busy) || strobe) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	function automatic longint power_of_ten(input int exponent);
		longint p;
		p = 1;
		for (int i = 0; i < exponent; i++) begin
			p = p * 10;
		end
		return p;
	endfunction

	// Random number: raw random values, a spread of digit counts, decade boundaries and extremes
	function automatic logic signed [31:0] pick_number();
		longint lo;
		longint hi;
		longint n;
		int     n_digits;
		case ($urandom_range(3))
			0: begin
				return $urandom;
			end
			1: begin
				n_digits = $urandom_range(1, 10);
				lo = (n_digits == 1) ? 0 : power_of_ten(n_digits - 1);
				hi = power_of_ten(n_digits) - 1;
				if (hi > 64'sd2147483647) begin
					hi = 64'sd2147483647;
				end
				n = lo + ($urandom % (hi - lo + 1));
				if ($urandom_range(1)) begin
					n = -n;
				end
				return 32'(n);
			end
			2: begin
				n = power_of_ten($urandom_range(0, 9)) + $urandom_range(0, 2) - 1;
				if ($urandom_range(1)) begin
					n = -n;
				end
				return 32'(n);
			end
			default: begin
				case ($urandom_range(4))
					0: return 32'h7fff_ffff;
					1: return 32'h8000_0000;
					2: return 32'h8000_0001;
					3: return 32'hffff_ffff;
					default: return 32'h0000_0000;
				endcase
			end
		endcase
	endfunction

	// Present one number after a random gap; start stays high into the next item
	task send_number(input logic signed [31:0] number, input int idle_pct);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			in_value <= $urandom;
			@(posedge clk);
		end
		start <= 1'b1;
		in_value <= number;
		do @(posedge clk); while (busy);
	endtask

	task send_random_numbers(input int count, input int idle_pct);
		for (int i = 0; i < count; i++) begin
			send_number(pick_number(), idle_pct);
		end
	endtask

	logic signed [31:0] directed_numbers[] = '{
		32'sd0, 32'sd1, -32'sd1, 32'sd9, -32'sd9, 32'sd10, -32'sd10, 32'sd99,
		32'sd100, -32'sd101, 32'sd2147483647, 32'h8000_0000, -32'sd2147483647,
		32'sd1000000000, 32'sd999999999, -32'sd1000000000, 32'sd1234567890,
		-32'sd1234567890, 32'h5555_5555, 32'haaaa_aaaa, 32'sd12345, -32'sd7
	};

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: zero, single digits, decade edges, extremes, bit patterns
		foreach (directed_numbers[i]) begin
			send_number(directed_numbers[i], 26);
		end

		// Random: sender idles sometimes, then often, then never
		send_random_numbers(50, 26);
		send_random_numbers(50, 67);
		send_random_numbers(50, 0);
		start <= 1'b0;

		// Drain the remaining characters, then let the pipeline settle
		while (board.pending_chars.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (board.pending_chars.size() != 0) begin
			board.report_mismatch($sformatf("%0d characters never arrived",
				board.pending_chars.size()));
		end
		if (board.mismatch_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

>>> signed_int_to_decimal_ascii.f
+incdir+src
src/sida_pkg.sv
src/sida_dabble_stage.sv
src/signed_int_to_decimal_ascii.sv
src/sida_checker.sv
dv/signed_int_to_decimal_ascii_tb.sv
